[hw/rtl/erg_pkg.sv]
// Shared types and constants for the Euclidean rhythm generator.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package erg_pkg;

    localparam int STEP_W        = 7;    // width of step_count, onset_count, pattern_length
    localparam int PAT_W         = 64;   // width of pattern_bits
    localparam int MAX_STEPS_DEF = 64;
    localparam int S_TDATA_W     = 16;   // two 7-bit fields, padded to whole bytes
    localparam int M_TDATA_W     = 72;   // 64 + 7 bits, padded to whole bytes

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_TAIL,
        ST_ALIGN,
        ST_DONE
    } erg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take the incoming beat and set up level 0
        logic copy;      // append one copy of the previous level, step the quotient
        logic tail;      // append the level before that and close the level
        logic shift;     // shift the pattern right by one step
        logic out_load;  // move the finished pattern into the output register
    } erg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;   // incoming beat asks for no onsets or all onsets
        logic can_copy;  // another copy fits into the running quotient
        logic top;       // the level in work is the top of the expansion
        logic aligned;   // pattern starts with an onset, or holds none
    } erg_status_t;

endpackage

[hw/rtl/erg_ctrl.sv]
// Controller of the Euclidean rhythm generator: sequences load, expansion,
// alignment and result hand-off, and owns the result valid flag.
// Depends on erg_pkg.
module erg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  erg_pkg::erg_status_t status,
    output erg_pkg::erg_cmd_t    cmd
);
    import erg_pkg::*;

    erg_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.trivial ? ST_DONE : ST_COPY;
                end
            end
            ST_COPY: begin
                if (status.can_copy) begin
                    cmd.copy = 1'b1;
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                cmd.tail   = 1'b1;
                state_next = status.top ? ST_ALIGN : ST_COPY;
            end
            ST_ALIGN: begin
                if (status.aligned) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/erg_dpath.sv]
// Datapath of the Euclidean rhythm generator: input saturation, the
// quotient/remainder chain, level-by-level pattern build, alignment, result.
// Depends on erg_pkg.
module erg_dpath #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
    input  logic                                  aclk,
    input  logic [erg_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic [0:0]                            s_tuser,
    input  erg_pkg::erg_cmd_t                     cmd,
    output erg_pkg::erg_status_t                  status,
    output logic [erg_pkg::PAT_W-1:0]             pattern_bits,
    output logic [erg_pkg::STEP_W-1:0]            pattern_length
);
    import erg_pkg::*;

    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam logic [STEP_W-1:0] NMax   = STEP_W'(MAX_STEPS);
    localparam logic [NW:0]       LenMax = (NW + 1)'(MAX_STEPS);

    // Incoming fields and their saturated values.
    logic [STEP_W-1:0] n_in, k_in, n_sat, k_sat, b_sat;
    logic              anti_in;

    logic [NW-1:0]        n_reg, d_reg, r_reg;
    logic                 anti_reg, triv_reg, full_reg, top_reg;
    logic [MAX_STEPS-1:0] p1_reg, p2_reg, cur_reg;
    logic [NW-1:0]        p1_len_reg, p2_len_reg, cur_len_reg;
    logic [PAT_W-1:0]     out_pat_reg;
    logic [STEP_W-1:0]    out_len_reg;

    logic [NW-1:0]        divisor;
    logic [MAX_STEPS-1:0] copy_bits, tail_bits, n_mask, final_pat;
    logic [NW-1:0]        copy_len, tail_len;

    function automatic logic [MAX_STEPS-1:0] app_bits(
        input logic [MAX_STEPS-1:0] a,
        input logic [NW-1:0]        alen,
        input logic [MAX_STEPS-1:0] b
    );
        return a | (b << alen);
    endfunction

    function automatic logic [NW-1:0] app_len(
        input logic [NW-1:0] alen,
        input logic [NW-1:0] blen
    );
        logic [NW:0] sum;
        sum = {1'b0, alen} + {1'b0, blen};
        return (sum > LenMax) ? NW'(MAX_STEPS) : sum[NW-1:0];
    endfunction

    assign n_in    = s_tdata[STEP_W-1:0];
    assign k_in    = s_tdata[2*STEP_W-1:STEP_W];
    assign anti_in = s_tuser[0];

    always_comb begin
        if (n_in > NMax) begin
            n_sat = NMax;
        end else if (n_in == '0) begin
            n_sat = STEP_W'(1);
        end else begin
            n_sat = n_in;
        end
        k_sat = (k_in > n_sat) ? n_sat : k_in;
        b_sat = anti_in ? (n_sat - k_sat) : k_sat;
    end

    always_comb begin
        for (int i = 0; i < MAX_STEPS; i++) begin
            n_mask[i] = (i < int'(n_reg));
        end
    end

    // The top level divides by one, so it emits d copies; lower levels divide by r.
    assign divisor   = top_reg ? NW'(1) : r_reg;
    assign copy_bits = app_bits(cur_reg, cur_len_reg, p1_reg);
    assign copy_len  = app_len(cur_len_reg, p1_len_reg);
    // Below the top the remainder is never zero, so the older level always follows.
    assign tail_bits = (!top_reg || r_reg != '0) ? app_bits(cur_reg, cur_len_reg, p2_reg)
                                                  : cur_reg;
    assign tail_len  = (!top_reg || r_reg != '0) ? app_len(cur_len_reg, p2_len_reg)
                                                  : cur_len_reg;

    always_comb begin
        if (triv_reg) begin
            final_pat = full_reg ? n_mask : '0;
        end else if (anti_reg) begin
            final_pat = ~cur_reg & n_mask;
        end else begin
            final_pat = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg       <= NW'(n_sat);
            anti_reg    <= anti_in;
            triv_reg    <= (k_sat == '0) || (k_sat == n_sat);
            full_reg    <= (k_sat == n_sat);
            d_reg       <= NW'(n_sat - b_sat);
            r_reg       <= NW'(b_sat);
            top_reg     <= 1'b0;
            p1_reg      <= '0;              // level -1: one rest
            p1_len_reg  <= NW'(1);
            p2_reg      <= MAX_STEPS'(1);   // level -2: one onset
            p2_len_reg  <= NW'(1);
            cur_reg     <= '0;
            cur_len_reg <= '0;
        end
        if (cmd.copy) begin
            cur_reg     <= copy_bits;
            cur_len_reg <= copy_len;
            d_reg       <= d_reg - divisor;
        end
        if (cmd.tail) begin
            if (top_reg) begin
                cur_reg <= tail_bits & n_mask;
            end else begin
                p2_reg      <= p1_reg;
                p2_len_reg  <= p1_len_reg;
                p1_reg      <= tail_bits;
                p1_len_reg  <= tail_len;
                cur_reg     <= '0;
                cur_len_reg <= '0;
                d_reg       <= r_reg;
                r_reg       <= d_reg;
                top_reg     <= (d_reg <= NW'(1));
            end
        end
        // Bits below the first onset are zero, so the rotation is a plain shift.
        if (cmd.shift) begin
            cur_reg <= cur_reg >> 1;
        end
        if (cmd.out_load) begin
            out_pat_reg <= PAT_W'(final_pat);
            out_len_reg <= STEP_W'(n_reg);
        end
    end

    assign status.trivial  = (k_sat == '0) || (k_sat == n_sat);
    assign status.can_copy = (d_reg >= divisor);
    assign status.top      = top_reg;
    assign status.aligned  = cur_reg[0] || (cur_reg == '0);

    assign pattern_bits   = out_pat_reg;
    assign pattern_length = out_len_reg;

endmodule

[hw/rtl/euclidean_rhythm_generator.sv]
// Top level of the Euclidean rhythm generator: controller plus datapath.
// Depends on erg_pkg, erg_ctrl and erg_dpath.
//
//  Channel | Direction | tdata (low bit up)                      | tuser
//  s_      | in        | step_count[6:0], onset_count[13:7]      | anti_mode
//  m_      | out       | pattern_bits[63:0], pattern_length[70:64] | -
//
// One request is processed at a time: a load step, then per expansion level
// the quotient copies, a check and a tail step, then one alignment shift per step
// ahead of the first onset and a final check, and a hand-off that waits for the
// output register to be free; no onsets or all onsets skip expansion and alignment.
// The quotient loop in the datapath adds one copy per cycle.
// Reset is synchronous and active low; it clears the controller and result valid.
// A new request is taken while an earlier result waits; a stalled result holds.
module euclidean_rhythm_generator #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [erg_pkg::S_TDATA_W-1:0]     s_tdata,   // step_count, onset_count
    input  logic [0:0]                        s_tuser,   // anti_mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [erg_pkg::M_TDATA_W-1:0]     m_tdata    // pattern_bits, pattern_length
);
    import erg_pkg::*;

    erg_cmd_t          cmd;
    erg_status_t       status;
    logic [PAT_W-1:0]  pattern_bits;
    logic [STEP_W-1:0] pattern_length;

    erg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    erg_dpath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .aclk           (aclk),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .cmd            (cmd),
        .status         (status),
        .pattern_bits   (pattern_bits),
        .pattern_length (pattern_length)
    );

    assign m_tdata = {{(M_TDATA_W - PAT_W - STEP_W){1'b0}}, pattern_length, pattern_bits};

endmodule

[hw/rtl/erg_checker.sv]
// Port-level checks for the Euclidean rhythm generator, bound to the top level.
// Depends on erg_pkg and euclidean_rhythm_generator.
module erg_checker #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [erg_pkg::M_TDATA_W-1:0]     m_tdata
);
    import erg_pkg::*;

    logic [STEP_W-1:0] len;
    logic [PAT_W-1:0]  len_mask;

    assign len = m_tdata[PAT_W+STEP_W-1:PAT_W];

    always_comb begin
        for (int i = 0; i < PAT_W; i++) begin
            len_mask[i] = (i < int'(len));
        end
    end

    // A held result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // After a request is taken the block is busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one still in work");

    // No onset lies beyond the pattern length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PAT_W-1:0] & ~len_mask) == '0)
        else $error("onset above pattern length");

    // The reported length stays within the supported step range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (len != '0) && (int'(len) <= MAX_STEPS))
        else $error("pattern length out of range");

endmodule

bind euclidean_rhythm_generator erg_checker #(.MAX_STEPS(MAX_STEPS)) u_erg_checker (.*);
